@@ rtl/ddgp_pkg.sv @@
// ----------------------------------------------------------------------------
// ddgp_pkg: shared types and constants of the go-to-point controller
// Register indexes, reset values, CORDIC angle table and payload structs.
// ----------------------------------------------------------------------------
package ddgp_pkg;

   localparam int unsigned CordicSteps = 15;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CSR_ANGULAR_GAIN  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LINEAR_GAIN   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ANGULAR_LIMIT = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_LINEAR_LIMIT  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_STOP_DISTANCE = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_ROBOT_RADIUS  = 3'd5;

   localparam logic [15:0] ANGULAR_GAIN_RESET  = 16'd4915;
   localparam logic [15:0] LINEAR_GAIN_RESET   = 16'd4096;
   localparam logic [15:0] ANGULAR_LIMIT_RESET = 16'd12288;
   localparam logic [15:0] LINEAR_LIMIT_RESET  = 16'd4096;
   localparam logic [15:0] STOP_DISTANCE_RESET = 16'd287;
   localparam logic [15:0] ROBOT_RADIUS_RESET  = 16'd287;

   localparam logic signed [25:0] GAIN_INV_Q24 = 26'sd10188014;
   localparam logic signed [18:0] PI_Q16 = 19'sd205887;

   typedef struct packed {
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic signed [15:0] pose_x;
      logic signed [15:0] pose_y;
      logic signed [15:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [15:0] right_speed;
      logic signed [15:0] left_speed;
      logic               arrived;
   } rsp_type;

   typedef struct packed {
      logic [15:0] angular_gain;
      logic [15:0] linear_gain;
      logic [15:0] angular_limit;
      logic [15:0] linear_limit;
      logic [15:0] stop_distance;
      logic [15:0] robot_radius;
   } csr_type;

   function automatic logic signed [17:0] atan_bam(input logic [3:0] i);
      case (i)
         4'd0:  atan_bam = 18'sd8192;
         4'd1:  atan_bam = 18'sd4836;
         4'd2:  atan_bam = 18'sd2555;
         4'd3:  atan_bam = 18'sd1297;
         4'd4:  atan_bam = 18'sd651;
         4'd5:  atan_bam = 18'sd326;
         4'd6:  atan_bam = 18'sd163;
         4'd7:  atan_bam = 18'sd81;
         4'd8:  atan_bam = 18'sd41;
         4'd9:  atan_bam = 18'sd20;
         4'd10: atan_bam = 18'sd10;
         4'd11: atan_bam = 18'sd5;
         4'd12: atan_bam = 18'sd3;
         4'd13: atan_bam = 18'sd1;
         4'd14: atan_bam = 18'sd1;
         default: atan_bam = 18'sd0;
      endcase
   endfunction

endpackage

@@ rtl/ddgp_if.sv @@
// ----------------------------------------------------------------------------
// ddgp_if: valid/ready channels of the go-to-point controller
// Request, response and register-write channels.
// ----------------------------------------------------------------------------
interface ddgp_req_if import ddgp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ddgp_rsp_if import ddgp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ddgp_csr_if import ddgp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [15:0]              wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/ddgp_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// ddgp_cordic_stage: one registered CORDIC micro-rotation of both engines
// Vectoring step for the bearing and rotation step for cos/sin of heading.
// ----------------------------------------------------------------------------
module ddgp_cordic_stage import ddgp_pkg::*; #(
   parameter int unsigned STEP = 0
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [27:0] vx_in,
   input  logic signed [27:0] vy_in,
   input  logic signed [17:0] vz_in,
   input  logic signed [27:0] rx_in,
   input  logic signed [27:0] ry_in,
   input  logic signed [17:0] rz_in,
   output logic signed [27:0] vx_ff,
   output logic signed [27:0] vy_ff,
   output logic signed [17:0] vz_ff,
   output logic signed [27:0] rx_ff,
   output logic signed [27:0] ry_ff,
   output logic signed [17:0] rz_ff
);
   localparam logic [3:0] StepIdx = 4'(STEP);
   logic signed [17:0] ang;
   assign ang = atan_bam(StepIdx);

   always_ff @(posedge clock) begin
      if (enable) begin
         if (vy_in > 0) begin
            vx_ff <= vx_in + (vy_in >>> STEP);
            vy_ff <= vy_in - (vx_in >>> STEP);
            vz_ff <= vz_in + ang;
         end else begin
            vx_ff <= vx_in - (vy_in >>> STEP);
            vy_ff <= vy_in + (vx_in >>> STEP);
            vz_ff <= vz_in - ang;
         end
         if (rz_in >= 0) begin
            rx_ff <= rx_in - (ry_in >>> STEP);
            ry_ff <= ry_in + (rx_in >>> STEP);
            rz_ff <= rz_in - ang;
         end else begin
            rx_ff <= rx_in + (ry_in >>> STEP);
            ry_ff <= ry_in - (rx_in >>> STEP);
            rz_ff <= rz_in + ang;
         end
      end
   end
endmodule

@@ rtl/diff_drive_goto_point_unit.sv @@
// ----------------------------------------------------------------------------
// diff_drive_goto_point_unit: pipelined go-to-goal wheel speed controller
// Pose and target in, right/left wheel speeds and arrival flag out.
// ----------------------------------------------------------------------------
// channel | direction | payload
// req     | in        | target_x, target_y, pose_x, pose_y, heading
// rsp     | out       | right_speed, left_speed, arrived
// csr     | in        | index (3 bits), wdata (16 bits)
// One request per cycle unless the output stalls; 15 CORDIC stages plus
// 8 stages of multiply, clamp, mix and output. The whole pipe advances when the
// output register is empty or being drained; a stall freezes every stage.
// Reset clears the valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module diff_drive_goto_point_unit import ddgp_pkg::*; (
   input logic   clock,
   input logic   reset,
   ddgp_req_if.sink   req,
   ddgp_rsp_if.source rsp,
   ddgp_csr_if.sink   csr
);
   localparam int unsigned Depth = CordicSteps + 8;

   csr_type csr_ff;
   logic [Depth-1:0] valid_ff;
   logic advance;

   assign advance = !valid_ff[Depth-1] || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;
   assign rsp.valid = valid_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{ANGULAR_GAIN_RESET, LINEAR_GAIN_RESET, ANGULAR_LIMIT_RESET,
                     LINEAR_LIMIT_RESET, STOP_DISTANCE_RESET, ROBOT_RADIUS_RESET};
      end else if (csr.valid) begin
         case (csr.index)
            CSR_ANGULAR_GAIN:  csr_ff.angular_gain  <= csr.wdata;
            CSR_LINEAR_GAIN:   csr_ff.linear_gain   <= csr.wdata;
            CSR_ANGULAR_LIMIT: csr_ff.angular_limit <= csr.wdata;
            CSR_LINEAR_LIMIT:  csr_ff.linear_limit  <= csr.wdata;
            CSR_STOP_DISTANCE: csr_ff.stop_distance <= csr.wdata;
            CSR_ROBOT_RADIUS:  csr_ff.robot_radius  <= csr.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[Depth-2:0], req.valid};
   end

   // stage 0: differences, quadrant prerotation, arrival test inputs
   logic signed [16:0] dx, dy;
   logic signed [27:0] vx0, vy0, rx0, ry0;
   logic signed [17:0] vz0, rz0;
   logic signed [16:0] hd;
   assign dx = 17'(req.data.target_x) - 17'(req.data.pose_x);
   assign dy = 17'(req.data.target_y) - 17'(req.data.pose_y);
   assign hd = 17'(req.data.heading);

   always_comb begin
      vx0 = 28'(dx) <<< 8;
      vy0 = 28'(dy) <<< 8;
      vz0 = '0;
      if (dx < 0) begin
         if (dy >= 0) begin
            vx0 = 28'(dy) <<< 8; vy0 = -(28'(dx) <<< 8); vz0 = 18'sd16384;
         end else begin
            vx0 = -(28'(dy) <<< 8); vy0 = 28'(dx) <<< 8; vz0 = -18'sd16384;
         end
      end
      rx0 = 28'(GAIN_INV_Q24);
      ry0 = '0;
      rz0 = 18'(hd);
      if (hd > 17'sd16384) begin
         rx0 = '0; ry0 = 28'(GAIN_INV_Q24); rz0 = 18'(hd) - 18'sd16384;
      end else if (hd < -17'sd16384) begin
         rx0 = '0; ry0 = -28'(GAIN_INV_Q24); rz0 = 18'(hd) + 18'sd16384;
      end
   end

   logic signed [27:0] vx [CordicSteps+1];
   logic signed [27:0] vy [CordicSteps+1];
   logic signed [17:0] vz [CordicSteps+1];
   logic signed [27:0] rx [CordicSteps+1];
   logic signed [27:0] ry [CordicSteps+1];
   logic signed [17:0] rz [CordicSteps+1];
   assign vx[0] = vx0; assign vy[0] = vy0; assign vz[0] = vz0;
   assign rx[0] = rx0; assign ry[0] = ry0; assign rz[0] = rz0;

   // side data that rides along the CORDIC stages
   logic signed [16:0] dx_ff [CordicSteps];
   logic signed [16:0] dy_ff [CordicSteps];
   logic signed [15:0] hd_ff [CordicSteps];

   for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
      ddgp_cordic_stage #(.STEP(g)) u_stage (
         .clock(clock), .enable(advance),
         .vx_in(vx[g]), .vy_in(vy[g]), .vz_in(vz[g]),
         .rx_in(rx[g]), .ry_in(ry[g]), .rz_in(rz[g]),
         .vx_ff(vx[g+1]), .vy_ff(vy[g+1]), .vz_ff(vz[g+1]),
         .rx_ff(rx[g+1]), .ry_ff(ry[g+1]), .rz_ff(rz[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff[0] <= dx; dy_ff[0] <= dy; hd_ff[0] <= req.data.heading;
         for (int k = 1; k < CordicSteps; k++) begin
            dx_ff[k] <= dx_ff[k-1]; dy_ff[k] <= dy_ff[k-1];
            hd_ff[k] <= hd_ff[k-1];
         end
      end
   end

   localparam int unsigned L = CordicSteps - 1;
   logic signed [17:0] bear;
   assign bear = vz[CordicSteps];

   // post stage A: squares, error, projection products
   logic signed [33:0] dxx_ff, dyy_ff;
   logic signed [15:0] e_ff;
   logic signed [44:0] pcx_ff, pcy_ff;
   logic [31:0] sd2_ff;
   logic signed [15:0] e_in;
   assign e_in = 16'(bear - 18'(hd_ff[L]));
   always_ff @(posedge clock) begin
      if (advance) begin
         dxx_ff <= 34'(dx_ff[L]) * 34'(dx_ff[L]);
         dyy_ff <= 34'(dy_ff[L]) * 34'(dy_ff[L]);
         e_ff <= e_in;
         pcx_ff <= 45'(dx_ff[L]) * 45'(rx[CordicSteps]);
         pcy_ff <= 45'(dy_ff[L]) * 45'(ry[CordicSteps]);
         sd2_ff <= csr_ff.stop_distance * csr_ff.stop_distance;
      end
   end

   // B: arrival, e_rad product, projection sum
   logic arr_b_ff;
   logic signed [34:0] erp_ff;
   logic signed [20:0] p_ff;
   logic signed [45:0] psum;
   assign psum = 46'(pcx_ff) + 46'(pcy_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         arr_b_ff <= (35'(dxx_ff) + 35'(dyy_ff)) <= 35'(sd2_ff);
         erp_ff <= 35'(e_ff) * 35'(PI_Q16);
         p_ff <= 21'(psum >>> 24);
      end
   end

   // C: gain products
   logic arr_c_ff;
   logic signed [15:0] erad;
   logic signed [33:0] wraw_ff;
   logic signed [38:0] vraw_ff;
   assign erad = 16'(erp_ff >>> 19);
   always_ff @(posedge clock) begin
      if (advance) begin
         arr_c_ff <= arr_b_ff;
         wraw_ff <= 34'($signed({1'b0, csr_ff.angular_gain})) * 34'(erad);
         vraw_ff <= 39'($signed({1'b0, csr_ff.linear_gain})) * 39'(p_ff);
      end
   end

   // D: shift and clamp
   logic arr_d_ff;
   logic signed [16:0] w_ff, v_ff;
   logic signed [21:0] ws;
   logic signed [26:0] vs;
   logic signed [21:0] al;
   logic signed [26:0] ll;
   assign ws = 22'(wraw_ff >>> 12);
   assign vs = 27'(vraw_ff >>> 12);
   assign al = 22'({1'b0, csr_ff.angular_limit});
   assign ll = 27'({1'b0, csr_ff.linear_limit});
   always_ff @(posedge clock) begin
      if (advance) begin
         arr_d_ff <= arr_c_ff;
         if (ws > al) w_ff <= 17'(al);
         else if (ws < -al) w_ff <= 17'(-al);
         else w_ff <= 17'(ws);
         if (vs > ll) v_ff <= 17'(ll);
         else if (vs < -ll) v_ff <= 17'(-ll);
         else v_ff <= 17'(vs);
      end
   end

   // E: radius product
   logic arr_e_ff;
   logic signed [16:0] v_e_ff;
   logic signed [33:0] rwp_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         arr_e_ff <= arr_d_ff;
         v_e_ff <= v_ff;
         rwp_ff <= 34'($signed({1'b0, csr_ff.robot_radius})) * 34'(w_ff);
      end
   end

   // F: wheel mix
   logic arr_f_ff;
   logic signed [22:0] rt_ff, lt_ff;
   logic signed [21:0] rw;
   assign rw = 22'(rwp_ff >>> 12);
   always_ff @(posedge clock) begin
      if (advance) begin
         arr_f_ff <= arr_e_ff;
         rt_ff <= 23'(v_e_ff) + 23'(rw);
         lt_ff <= 23'(v_e_ff) - 23'(rw);
      end
   end

   function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
      if (v > 23'sd32767) sat16 = 16'sh7fff;
      else if (v < -23'sd32768) sat16 = 16'sh8000;
      else sat16 = 16'(v);
   endfunction

   // G, H: saturate, then output register
   rsp_type g_ff, out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         g_ff.arrived <= arr_f_ff;
         g_ff.right_speed <= arr_f_ff ? 16'sd0 : sat16(rt_ff);
         g_ff.left_speed <= arr_f_ff ? 16'sd0 : sat16(lt_ff);
         out_ff <= g_ff;
      end
   end
   assign rsp.data = out_ff;

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("request ready mismatch");
   a_arr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.arrived |-> rsp.data.right_speed == 16'sd0 &&
      rsp.data.left_speed == 16'sd0)
      else $error("arrived with nonzero speed");
`endif
endmodule

@@ test/tb_wheel_speed_scoreboard.sv @@
// ----------------------------------------------------------------------------
// tb_wheel_speed_scoreboard: expected wheel speeds of the go-to-point unit
// Predicts right/left speed and arrival for each accepted request and
// checks responses in order against the oldest prediction.
// ----------------------------------------------------------------------------
package tb_wheel_speed_pkg;
   import ddgp_pkg::*;

   localparam int AtanCounts [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1, 1};

   class wheel_speed_scoreboard;
      csr_type  regs;
      rsp_type  pending[$];
      int       errors;

      function new();
         regs.angular_gain  = ANGULAR_GAIN_RESET;
         regs.linear_gain   = LINEAR_GAIN_RESET;
         regs.angular_limit = ANGULAR_LIMIT_RESET;
         regs.linear_limit  = LINEAR_LIMIT_RESET;
         regs.stop_distance = STOP_DISTANCE_RESET;
         regs.robot_radius  = ROBOT_RADIUS_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_ANGULAR_GAIN:  regs.angular_gain  = val;
            CSR_LINEAR_GAIN:   regs.linear_gain   = val;
            CSR_ANGULAR_LIMIT: regs.angular_limit = val;
            CSR_LINEAR_LIMIT:  regs.linear_limit  = val;
            CSR_STOP_DISTANCE: regs.stop_distance = val;
            CSR_ROBOT_RADIUS:  regs.robot_radius  = val;
            default: ;
         endcase
      endfunction

      // >>> on longint is arithmetic: rounds toward minus infinity
      function longint clamp_sym(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function longint sat16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint bearing(longint x, longint y);
         longint z, t, xs, ys;
         z = 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = 16384;
            end else begin
               t = x; x = -y; y = t; z = -16384;
            end
         end
         for (int i = 0; i < 15; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (y > 0) begin
               x = x + ys; y = y - xs; z += AtanCounts[i];
            end else begin
               x = x - ys; y = y + xs; z -= AtanCounts[i];
            end
         end
         return z;
      endfunction

      function void note_request(req_type r);
         longint dx, dy, head, sd, e, erad, w, x, y, z, xs, ys, p, v, rw;
         logic [15:0] e16;
         rsp_type o;
         dx = longint'(r.target_x) - longint'(r.pose_x);
         dy = longint'(r.target_y) - longint'(r.pose_y);
         head = longint'(r.heading);
         sd = longint'(regs.stop_distance);
         if (dx * dx + dy * dy <= sd * sd) begin
            o.right_speed = 0; o.left_speed = 0; o.arrived = 1'b1;
            pending = {pending, o};
            return;
         end
         e16 = 16'(bearing(dx * 256, dy * 256) - head);
         e = longint'($signed(e16));
         erad = (e * 205887) >>> 19;
         w = clamp_sym((longint'(regs.angular_gain) * erad) >>> 12,
                       longint'(regs.angular_limit));
         x = 10188014; y = 0; z = head;
         if (z > 16384) begin
            x = 0; y = 10188014; z -= 16384;
         end else if (z < -16384) begin
            x = 0; y = -10188014; z += 16384;
         end
         for (int i = 0; i < 15; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (z >= 0) begin
               x = x - ys; y = y + xs; z -= AtanCounts[i];
            end else begin
               x = x + ys; y = y - xs; z += AtanCounts[i];
            end
         end
         p = (dx * x + dy * y) >>> 24;
         v = clamp_sym((longint'(regs.linear_gain) * p) >>> 12,
                       longint'(regs.linear_limit));
         rw = (longint'(regs.robot_radius) * w) >>> 12;
         o.right_speed = 16'(sat16(v + rw));
         o.left_speed  = 16'(sat16(v - rw));
         o.arrived = 1'b0;
         pending = {pending, o};
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.right_speed !== exp_r.right_speed)
            $display("%0t: right_speed expected %0d actual %0d", $time,
                     exp_r.right_speed, got.right_speed);
         if (got.left_speed !== exp_r.left_speed)
            $display("%0t: left_speed expected %0d actual %0d", $time,
                     exp_r.left_speed, got.left_speed);
         if (got.arrived !== exp_r.arrived)
            $display("%0t: arrived expected %0b actual %0b", $time,
                     exp_r.arrived, got.arrived);
         if (got !== exp_r) errors++;
      endfunction
   endclass
endpackage

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the go-to-point wheel speed unit
// Directed and random poses under several register settings and
// idle/stall mixes; every response is checked against a prediction.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ddgp_pkg::*;
   import tb_wheel_speed_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddgp_req_if req_if ();
   ddgp_rsp_if rsp_if ();
   ddgp_csr_if csr_if ();

   diff_drive_goto_point_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   wheel_speed_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.wdata = '0;
   end

   // response side: ready toggles on falling edges, checks on rising edges
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
   end

   // valid stays high between back-to-back requests; drain() drops it
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.data <= r;
      req_if.valid <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [15:0] val);
      csr_if.index <= idx;
      csr_if.wdata <= val;
      csr_if.valid <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic set_regs(logic [15:0] ag, logic [15:0] lg, logic [15:0] al,
                           logic [15:0] ll, logic [15:0] sd, logic [15:0] rr);
      write_csr(CSR_ANGULAR_GAIN, ag);
      write_csr(CSR_LINEAR_GAIN, lg);
      write_csr(CSR_ANGULAR_LIMIT, al);
      write_csr(CSR_LINEAR_LIMIT, ll);
      write_csr(CSR_STOP_DISTANCE, sd);
      write_csr(CSR_ROBOT_RADIUS, rr);
      csr_if.valid <= 1'b0;
   endtask

   function automatic req_type random_request();
      req_type r;
      r.heading = 16'($urandom);
      case ($urandom_range(3))
         0: begin
            r = req_type'(80'({$urandom, $urandom, $urandom}));
         end
         1: begin
            // near the target: around the stop radius
            r.pose_x = 16'($urandom); r.pose_y = 16'($urandom);
            r.target_x = r.pose_x + 16'($signed($urandom_range(800)) - 400);
            r.target_y = r.pose_y + 16'($signed($urandom_range(800)) - 400);
         end
         default: begin
            r.pose_x = 16'($urandom_range(16383)) - 16'sd8192;
            r.pose_y = 16'($urandom_range(16383)) - 16'sd8192;
            r.target_x = 16'($urandom_range(16383)) - 16'sd8192;
            r.target_y = 16'($urandom_range(16383)) - 16'sd8192;
         end
      endcase
      return r;
   endfunction

   task automatic random_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) send_request(random_request());
      drain();
   endtask

   initial begin
      req_type r;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, on-target, each quadrant, wrap of heading error
      r = '{16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh0000}; send_request(r);
      r = '{-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000}; send_request(r);
      r = '{16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff}; send_request(r);
      r = '{16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd0}; send_request(r);
      r = '{16'sd287, 16'sd0, 16'sd0, 16'sd0, 16'sd0}; send_request(r);
      r = '{16'sd288, 16'sd0, 16'sd0, 16'sd0, 16'sd0}; send_request(r);
      r = '{-16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0}; send_request(r);
      r = '{-16'sd4096, 16'sd1, 16'sd0, 16'sd0, -16'sd32768}; send_request(r);
      r = '{-16'sd4096, -16'sd1, 16'sd0, 16'sd0, 16'sd32767}; send_request(r);
      r = '{16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd16384}; send_request(r);
      r = '{16'sd0, -16'sd4096, 16'sd0, 16'sd0, -16'sd16384}; send_request(r);
      r = '{16'sd3000, 16'sd3000, 16'sd0, 16'sd0, 16'sd16385}; send_request(r);
      r = '{16'sd3000, -16'sd3000, 16'sd0, 16'sd0, -16'sd16385}; send_request(r);
      drain();

      random_phase(250, 0, 0);
      random_phase(200, 77, 0);
      set_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0, 16'hffff);
      send_request('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0});
      random_phase(250, 0, 77);
      set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 16'd0);
      random_phase(100, 28, 28);
      set_regs(16'd8000, 16'd20000, 16'd0, 16'd30000, 16'd50, 16'd40000);
      random_phase(150, 28, 28);
      set_regs(16'd30000, 16'd6000, 16'd40000, 16'd0, 16'd400, 16'd2000);
      random_phase(150, 77, 0);
      set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom_range(2000)), 16'($urandom));
      random_phase(250, 0, 0);
      set_regs(ANGULAR_GAIN_RESET, LINEAR_GAIN_RESET, ANGULAR_LIMIT_RESET,
               LINEAR_LIMIT_RESET, STOP_DISTANCE_RESET, ROBOT_RADIUS_RESET);
      random_phase(300, 28, 28);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
